// ===== hdl/gpbt_pkg.sv =====
`timescale 1ns / 1ps

package gpbt_pkg;

  // field widths
  localparam int unsigned GRP_W = 4;
  localparam int unsigned PIN_W = 3;
  localparam int unsigned CNT_W = 10;
  localparam int unsigned KEY_W = 6;
  localparam int unsigned DUR_W = 16;

  // groups at or above this are not driven
  localparam logic [GRP_W-1:0] GROUP_LIMIT = 4'd12;

  // ms to 100 ms ticks: d / 100 == (d * 83887) >> 23 for every 16 bit d
  localparam int unsigned PROD_W = 33;
  localparam logic [PROD_W-1:0] TICK_MUL = 33'd83887;
  localparam int unsigned TICK_SHIFT = 23;

  // long press threshold after reset
  localparam logic [KEY_W-1:0] LONG_PRESS_RESET = 6'd50;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

  // command broadcast to every cell for the current transaction
  typedef struct packed {
    logic             is_req;
    logic [GRP_W-1:0] grp;
    logic [PIN_W-1:0] idx;
    logic             mode;
    logic [CNT_W-1:0] ticks;
    logic             stop;
    logic             lvl;
  } cmd_t;

  // token passed from cell to cell
  typedef struct packed {
    logic valid;
    logic found;
    logic free_found;
  } token_t;

  // pin write reported by a cell
  typedef struct packed {
    logic             wr;
    logic [GRP_W-1:0] grp;
    logic [PIN_W-1:0] idx;
    logic             lvl;
  } cell_res_t;

endpackage

// ===== hdl/gpbt_cell.sv =====
`timescale 1ns / 1ps

module gpbt_cell #(
  parameter int unsigned CELL_ID = 0,
  parameter int unsigned IDX_W   = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gpbt_pkg::cmd_t      cmd_i,
  input  gpbt_pkg::token_t    tok_i,
  input  logic [IDX_W-1:0]    free_idx_i,
  input  logic                alloc_en_i,
  input  logic [IDX_W-1:0]    alloc_idx_i,
  output gpbt_pkg::token_t    tok_o,
  output logic [IDX_W-1:0]    free_idx_o,
  output gpbt_pkg::cell_res_t res_o
);
  import gpbt_pkg::*;

  localparam logic [IDX_W-1:0] MY_ID = IDX_W'(CELL_ID);

  token_t           tok_q;
  logic [IDX_W-1:0] free_idx_q;

  logic             active_q, active_d;
  logic             mode_q, mode_d;
  logic [GRP_W-1:0] grp_q, grp_d;
  logic [PIN_W-1:0] idx_q, idx_d;
  logic             lvl_q, lvl_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] per_q, per_d;

  logic             here;
  logic             hit;
  logic             advance;
  logic             expire;
  logic             alloc_here;
  logic [CNT_W-1:0] cnt_inc;

  // what this cell does while it holds the token
  always_comb begin
    here       = tok_q.valid;
    hit        = here && cmd_i.is_req && active_q &&
                 (grp_q == cmd_i.grp) && (idx_q == cmd_i.idx);
    advance    = here && !cmd_i.is_req && active_q;
    cnt_inc    = cnt_q + CNT_W'(1);
    expire     = advance && (cnt_inc >= per_q);
    alloc_here = alloc_en_i && (alloc_idx_i == MY_ID);
  end

  // token and search results to the next cell
  always_comb begin
    tok_o.valid      = here;
    tok_o.found      = tok_q.found | hit;
    tok_o.free_found = tok_q.free_found | !active_q;
    free_idx_o       = tok_q.free_found ? free_idx_q : MY_ID;
  end

  // pin write on expiry or toggle, zero when idle so results can be or-ed
  always_comb begin
    res_o = '0;
    if (expire) begin
      res_o.wr  = 1'b1;
      res_o.grp = grp_q;
      res_o.idx = idx_q;
      res_o.lvl = ~lvl_q;
    end
  end

  // entry update
  always_comb begin
    active_d = active_q;
    mode_d   = mode_q;
    grp_d    = grp_q;
    idx_d    = idx_q;
    lvl_d    = lvl_q;
    cnt_d    = cnt_q;
    per_d    = per_q;
    if (alloc_here) begin
      lvl_d = cmd_i.lvl;
      cnt_d = '0;
      if (!cmd_i.stop) begin
        active_d = 1'b1;
        mode_d   = cmd_i.mode;
        grp_d    = cmd_i.grp;
        idx_d    = cmd_i.idx;
        per_d    = cmd_i.ticks;
      end
    end else if (hit) begin
      if (cmd_i.stop) begin
        active_d = 1'b0;
      end else begin
        per_d = cmd_i.ticks;
      end
    end else if (advance) begin
      if (expire) begin
        cnt_d = '0;
        if (mode_q) begin
          lvl_d = ~lvl_q;
        end else begin
          active_d = 1'b0;
        end
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= '0;
      active_q <= 1'b0;
    end else begin
      tok_q    <= tok_i;
      active_q <= active_d;
    end
  end

  // entry payload, only read while active, and the free index from the previous cell
  always_ff @(posedge clk_i) begin
    free_idx_q <= free_idx_i;
    mode_q     <= mode_d;
    grp_q      <= grp_d;
    idx_q      <= idx_d;
    lvl_q      <= lvl_d;
    cnt_q      <= cnt_d;
    per_q      <= per_d;
  end

endmodule

// ===== hdl/gpbt_ctrl.sv =====
`timescale 1ns / 1ps

module gpbt_ctrl #(
  parameter int unsigned NUM_ENTRIES = 8,
  parameter int unsigned IDX_W       = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                command_i,
  input  logic [gpbt_pkg::GRP_W-1:0]          pin_group_i,
  input  logic [gpbt_pkg::PIN_W-1:0]          pin_index_i,
  input  logic                                timing_mode_i,
  input  logic [gpbt_pkg::DUR_W-1:0]          duration_ms_i,
  input  logic                                start_level_i,
  input  logic                                key_level_i,
  input  logic                                cfg_we_i,
  input  logic [gpbt_pkg::KEY_W-1:0]          cfg_data_i,
  output logic                                busy_o,
  output gpbt_pkg::cmd_t                      cmd_o,
  output gpbt_pkg::token_t                    tok_o,
  input  gpbt_pkg::token_t                    tok_i,
  input  logic [IDX_W-1:0]                    free_idx_i,
  input  gpbt_pkg::cell_res_t                 res_i [NUM_ENTRIES],
  output logic                                alloc_en_o,
  output logic [IDX_W-1:0]                    alloc_idx_o,
  output logic                                result_valid_o,
  output logic                                write_valid_o,
  output logic [gpbt_pkg::GRP_W-1:0]          out_group_o,
  output logic [gpbt_pkg::PIN_W-1:0]          out_index_o,
  output logic                                out_level_o,
  output logic                                reset_trigger_o,
  output logic                                last_o
);
  import gpbt_pkg::*;

  state_e           state_q, state_d;
  logic             accept;
  logic             ignore_in;
  logic [PROD_W-1:0] prod;
  cmd_t             cmd_new;

  cmd_t             cmd_q;
  logic             ign_q;
  logic             key_q;
  logic             fnd_q;
  logic             ffound_q;
  logic [IDX_W-1:0] fidx_q;

  logic [KEY_W-1:0] lpt_q;
  logic [KEY_W-1:0] key_cnt_q, key_cnt_d;
  logic [KEY_W:0]   key_inc;
  logic             trig;

  cell_res_t        cres;
  logic             pend_v_q, pend_v_d;
  cell_res_t        pend_q, pend_d;

  logic             out_v_q, out_v_d;
  logic             wr_q, wr_d;
  logic [GRP_W-1:0] grp_q, grp_d;
  logic [PIN_W-1:0] idx_q, idx_d;
  logic             lvl_q, lvl_d;
  logic             trig_q, trig_d;
  logic             last_q, last_d;

  // accept and decode the incoming transaction
  always_comb begin
    accept        = start_i && (state_q == ST_IDLE);
    ignore_in     = command_i && (pin_group_i >= GROUP_LIMIT);
    prod          = {{(PROD_W-DUR_W){1'b0}}, duration_ms_i} * TICK_MUL;
    cmd_new.is_req = command_i;
    cmd_new.grp    = pin_group_i;
    cmd_new.idx    = pin_index_i;
    cmd_new.mode   = timing_mode_i;
    cmd_new.ticks  = prod[TICK_SHIFT +: CNT_W];
    cmd_new.stop   = (prod[TICK_SHIFT +: CNT_W] == '0);
    cmd_new.lvl    = start_level_i;
    tok_o.valid      = accept && !ignore_in;
    tok_o.found      = 1'b0;
    tok_o.free_found = 1'b0;
  end

  assign cmd_o  = cmd_q;
  assign busy_o = (state_q != ST_IDLE);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ignore_in ? ST_FINISH : ST_WALK;
        end
      end
      ST_WALK: begin
        if (tok_i.valid) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // at most one cell reports a write in any cycle
  always_comb begin
    cres = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      cres = cres | res_i[i];
    end
  end

  // long press counter, saturating at the threshold
  always_comb begin
    key_inc   = {1'b0, key_cnt_q} + (KEY_W+1)'(1);
    trig      = 1'b0;
    key_cnt_d = key_cnt_q;
    if (state_q == ST_FINISH && !cmd_q.is_req) begin
      if (key_q) begin
        key_cnt_d = '0;
      end else if (key_inc == {1'b0, lpt_q}) begin
        trig      = 1'b1;
        key_cnt_d = key_inc[KEY_W-1:0];
      end else if (key_inc > {1'b0, lpt_q}) begin
        key_cnt_d = lpt_q;
      end else begin
        key_cnt_d = key_inc[KEY_W-1:0];
      end
    end
  end

  // allocation of the first free entry
  always_comb begin
    alloc_en_o  = (state_q == ST_FINISH) && cmd_q.is_req && !ign_q && !fnd_q && ffound_q;
    alloc_idx_o = fidx_q;
  end

  // result sequencing: one write held back so the final one can carry last
  always_comb begin
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = 1'b0;
    wr_d     = 1'b0;
    grp_d    = '0;
    idx_d    = '0;
    lvl_d    = 1'b0;
    trig_d   = 1'b0;
    last_d   = 1'b0;
    unique case (state_q)
      ST_WALK: begin
        if (cres.wr) begin
          if (pend_v_q) begin
            out_v_d = 1'b1;
            wr_d    = 1'b1;
            grp_d   = pend_q.grp;
            idx_d   = pend_q.idx;
            lvl_d   = pend_q.lvl;
          end
          pend_v_d = 1'b1;
          pend_d   = cres;
        end
      end
      ST_FINISH: begin
        out_v_d  = 1'b1;
        last_d   = 1'b1;
        pend_v_d = 1'b0;
        if (cmd_q.is_req) begin
          wr_d = !ign_q && (fnd_q ? cmd_q.stop : ffound_q);
          if (wr_d) begin
            grp_d = cmd_q.grp;
            idx_d = cmd_q.idx;
            lvl_d = cmd_q.lvl;
          end
        end else begin
          trig_d = trig;
          if (pend_v_q) begin
            wr_d  = 1'b1;
            grp_d = pend_q.grp;
            idx_d = pend_q.idx;
            lvl_d = pend_q.lvl;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpt_q     <= LONG_PRESS_RESET;
      key_cnt_q <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lpt_q <= cfg_data_i;
      end
      key_cnt_q <= key_cnt_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
    end
  end

  // transaction and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_new;
      ign_q <= ignore_in;
      key_q <= key_level_i;
    end
    if (state_q == ST_WALK && tok_i.valid) begin
      fnd_q    <= tok_i.found;
      ffound_q <= tok_i.free_found;
      fidx_q   <= free_idx_i;
    end
    pend_q <= pend_d;
    wr_q   <= wr_d;
    grp_q  <= grp_d;
    idx_q  <= idx_d;
    lvl_q  <= lvl_d;
    trig_q <= trig_d;
    last_q <= last_d;
  end

  assign result_valid_o  = out_v_q;
  assign write_valid_o   = wr_q;
  assign out_group_o     = grp_q;
  assign out_index_o     = idx_q;
  assign out_level_o     = lvl_q;
  assign reset_trigger_o = trig_q;
  assign last_o          = last_q;

endmodule

// ===== hdl/gpio_pulse_blink_timer_table.sv =====
`timescale 1ns / 1ps

// Timed pin control table. A transaction is taken when start_i is high and
// busy_o is low; it is either one 100 ms tick (command_i 0) or a pin request
// (command_i 1). The entries sit in a row of NUM_ENTRIES cells and a token
// walks the row one cell per clock; busy_o stays high through the walk and a
// finish step (a request for group 12 or above skips the walk), and no new
// transaction is taken while busy_o is high. Every result is shown for
// exactly one cycle with result_valid_o and must be taken then, since the
// receiver has no way to stall the block. A tick gives one result per pin
// write, in entry order, or a single result without a write; a request
// always gives one result. last_o marks the final result of a transaction,
// which is shown in the first cycle with busy_o low, and reset_trigger_o can
// only be set on that result. The user must write long_press_ticks through
// cfg_we_i / cfg_data_i only while the block is idle; it is not enforced.
module gpio_pulse_blink_timer_table #(
  parameter int unsigned NUM_ENTRIES = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       command_i,
  input  logic [gpbt_pkg::GRP_W-1:0] pin_group_i,
  input  logic [gpbt_pkg::PIN_W-1:0] pin_index_i,
  input  logic                       timing_mode_i,
  input  logic [gpbt_pkg::DUR_W-1:0] duration_ms_i,
  input  logic                       start_level_i,
  input  logic                       key_level_i,
  input  logic                       cfg_we_i,
  input  logic [gpbt_pkg::KEY_W-1:0] cfg_data_i,
  output logic                       result_valid_o,
  output logic                       write_valid_o,
  output logic [gpbt_pkg::GRP_W-1:0] out_group_o,
  output logic [gpbt_pkg::PIN_W-1:0] out_index_o,
  output logic                       out_level_o,
  output logic                       reset_trigger_o,
  output logic                       last_o
);
  import gpbt_pkg::*;

  localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  cmd_t             cmd;
  token_t           tok_w      [NUM_ENTRIES+1];
  logic [IDX_W-1:0] free_idx_w [NUM_ENTRIES+1];
  cell_res_t        res_w      [NUM_ENTRIES];
  logic             alloc_en;
  logic [IDX_W-1:0] alloc_idx;

  assign free_idx_w[0] = '0;

  // sequencer, key counter and result stage
  gpbt_ctrl #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .command_i       (command_i),
    .pin_group_i     (pin_group_i),
    .pin_index_i     (pin_index_i),
    .timing_mode_i   (timing_mode_i),
    .duration_ms_i   (duration_ms_i),
    .start_level_i   (start_level_i),
    .key_level_i     (key_level_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .busy_o          (busy_o),
    .cmd_o           (cmd),
    .tok_o           (tok_w[0]),
    .tok_i           (tok_w[NUM_ENTRIES]),
    .free_idx_i      (free_idx_w[NUM_ENTRIES]),
    .res_i           (res_w),
    .alloc_en_o      (alloc_en),
    .alloc_idx_o     (alloc_idx),
    .result_valid_o  (result_valid_o),
    .write_valid_o   (write_valid_o),
    .out_group_o     (out_group_o),
    .out_index_o     (out_index_o),
    .out_level_o     (out_level_o),
    .reset_trigger_o (reset_trigger_o),
    .last_o          (last_o)
  );

  // row of entry cells
  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
    gpbt_cell #(
      .CELL_ID (g),
      .IDX_W   (IDX_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .tok_i       (tok_w[g]),
      .free_idx_i  (free_idx_w[g]),
      .alloc_en_i  (alloc_en),
      .alloc_idx_i (alloc_idx),
      .tok_o       (tok_w[g+1]),
      .free_idx_o  (free_idx_w[g+1]),
      .res_o       (res_w[g])
    );
  end

endmodule

// ===== hdl/gpbt_checker.sv =====
`timescale 1ns / 1ps

module gpbt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       result_valid_o,
  input logic       write_valid_o,
  input logic [3:0] out_group_o,
  input logic [2:0] out_index_o,
  input logic       out_level_o,
  input logic       reset_trigger_o,
  input logic       last_o
);
  import gpbt_pkg::*;

  // a started transaction always raises busy in the cycle after the start
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("transaction start did not raise busy");

  // final result comes after busy drops, earlier ones while busy
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy_o)
    else $error("final result while busy");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy_o && write_valid_o && !reset_trigger_o)
    else $error("non-final result outside a transaction or without a write");

  // results without a write carry zero pin fields, writes a legal group
  a_pin_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (write_valid_o ? (out_group_o < GROUP_LIMIT)
                        : (out_group_o == '0 && out_index_o == '0 && !out_level_o)))
    else $error("bad pin fields on result");

  // long press trigger only on a final result
  a_trig_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reset_trigger_o |-> result_valid_o && last_o)
    else $error("trigger outside a final result");

endmodule

bind gpio_pulse_blink_timer_table gpbt_checker u_gpbt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .result_valid_o  (result_valid_o),
  .write_valid_o   (write_valid_o),
  .out_group_o     (out_group_o),
  .out_index_o     (out_index_o),
  .out_level_o     (out_level_o),
  .reset_trigger_o (reset_trigger_o),
  .last_o          (last_o)
);
